/* rtl/core/cmbd_pkg.sv */
package cmbd_pkg;

    // Default geometry of the three memories, in byte address bits.
    parameter int RAM_ADDR_BITS_DEF     = 21;
    parameter int ROM_ADDR_BITS_DEF     = 19;
    parameter int SCRATCH_ADDR_BITS_DEF = 10;

    // Access modes.
    localparam logic [1:0] MODE_READ  = 2'd0;
    localparam logic [1:0] MODE_WRITE = 2'd1;
    localparam logic [1:0] MODE_LOAD  = 2'd2;
    localparam logic [1:0] MODE_NOP   = 2'd3;

    // Access sizes. The fourth code is handled as a word.
    localparam logic [1:0] SIZE_BYTE = 2'd0;
    localparam logic [1:0] SIZE_HALF = 2'd1;
    localparam logic [1:0] SIZE_WORD = 2'd2;

    // Memory map constants.
    localparam logic [12:0] SEG_SCRATCH   = 13'h1f80;
    localparam logic [12:0] SEG_ROM_BASE  = 13'h1fc0;
    localparam logic [15:0] SEG_EXPANSION = 16'h1f00;
    localparam logic [31:0] CACHE_PORT    = 32'hfffe0130;

    // Cache control codes.
    localparam logic [31:0] ISO_ON_A  = 32'h0000_0800;
    localparam logic [31:0] ISO_ON_B  = 32'h0000_0804;
    localparam logic [31:0] ISO_OFF_A = 32'h0000_0000;
    localparam logic [31:0] ISO_OFF_B = 32'h0001_e988;

    typedef enum logic [2:0] {
        RG_NONE,
        RG_SCRATCH,
        RG_HWREG,
        RG_RAM,
        RG_EXPANSION,
        RG_ROM,
        RG_CACHE_CTRL,
        RG_LOAD
    } region_t;

    typedef enum logic [1:0] {
        EV_NONE      = 2'd0,
        EV_ISOLATE   = 2'd1,
        EV_UNISOLATE = 2'd2
    } iso_event_t;

    typedef struct packed {
        logic [1:0]  mode;
        logic [1:0]  size;
        logic [31:0] address;
        logic [31:0] write_data;
    } in_t;

    typedef struct packed {
        logic [31:0] read_data;
        logic        hw_forward;
        logic [1:0]  isolation_event;
        logic        isolated_now;
    } out_t;

    // Decoded transaction as it sits in the execute stage.
    typedef struct packed {
        region_t     region;
        logic        wr;
        logic [1:0]  size;
        logic [31:0] address;
        logic [31:0] write_data;
    } dec_t;

    // Write command toward the memories; the address is the byte address.
    typedef struct packed {
        logic        ram_we;
        logic        rom_we;
        logic        scr_we;
        logic [31:0] addr;
        logic [31:0] data;
    } mem_wr_t;

    function automatic logic [31:0] size_mask(input logic [1:0] size);
        logic [31:0] m;
        unique case (size)
            SIZE_BYTE: m = 32'h0000_00ff;
            SIZE_HALF: m = 32'h0000_ffff;
            default:   m = 32'hffff_ffff;
        endcase
        return m;
    endfunction

    function automatic logic [4:0] lane_shift(input logic [1:0] size, input logic [1:0] lane);
        logic [4:0] sh;
        unique case (size)
            SIZE_BYTE: sh = {lane, 3'b000};
            SIZE_HALF: sh = {lane[1], 4'b0000};
            default:   sh = 5'd0;
        endcase
        return sh;
    endfunction

    function automatic logic [31:0] lane_read(input logic [31:0] word, input logic [1:0] size,
                                              input logic [1:0] lane);
        return (word >> lane_shift(size, lane)) & size_mask(size);
    endfunction

    function automatic logic [31:0] lane_merge(input logic [31:0] old, input logic [31:0] data,
                                               input logic [1:0] size, input logic [1:0] lane);
        logic [31:0] m;
        m = size_mask(size) << lane_shift(size, lane);
        return (old & ~m) | ((data << lane_shift(size, lane)) & m);
    endfunction

endpackage

/* rtl/core/cmbd_decode.sv */
module cmbd_decode #(
    parameter int ROM_ADDR_BITS     = cmbd_pkg::ROM_ADDR_BITS_DEF,
    parameter int SCRATCH_ADDR_BITS = cmbd_pkg::SCRATCH_ADDR_BITS_DEF
) (
    input  cmbd_pkg::in_t  req,
    output cmbd_pkg::dec_t dec
);

    localparam logic [12:0] ROM_SEG_END =
        cmbd_pkg::SEG_ROM_BASE + 13'(1 << (ROM_ADDR_BITS - 16));

    logic [15:0] seg;
    logic [12:0] low;
    logic        area_ok;
    logic        wr;
    logic [1:0]  size_n;

    assign seg     = req.address[31:16];
    assign low     = seg[12:0];
    assign area_ok = (seg[15:13] == 3'b000) || (seg[15:13] == 3'b100) ||
                     (seg[15:13] == 3'b101);
    assign wr      = (req.mode == cmbd_pkg::MODE_WRITE);
    assign size_n  = (req.size == 2'd3) ? cmbd_pkg::SIZE_WORD : req.size;

    always_comb
    begin
        dec.wr         = wr;
        dec.size       = size_n;
        dec.address    = req.address;
        dec.write_data = req.write_data;
        if (req.mode == cmbd_pkg::MODE_NOP)
        begin
            dec.region = cmbd_pkg::RG_NONE;
        end
        else if (req.mode == cmbd_pkg::MODE_LOAD)
        begin
            dec.region = cmbd_pkg::RG_LOAD;
        end
        else if (area_ok && low == cmbd_pkg::SEG_SCRATCH)
        begin
            dec.region = (req.address[15:SCRATCH_ADDR_BITS] == '0) ?
                         cmbd_pkg::RG_SCRATCH : cmbd_pkg::RG_HWREG;
        end
        else if (area_ok && low[12:7] == '0)
        begin
            dec.region = cmbd_pkg::RG_RAM;
        end
        else if (seg == cmbd_pkg::SEG_EXPANSION)
        begin
            dec.region = cmbd_pkg::RG_EXPANSION;
        end
        else if (area_ok && low >= cmbd_pkg::SEG_ROM_BASE && low < ROM_SEG_END)
        begin
            dec.region = cmbd_pkg::RG_ROM;
        end
        else if (wr && size_n == cmbd_pkg::SIZE_WORD && req.address == cmbd_pkg::CACHE_PORT)
        begin
            dec.region = cmbd_pkg::RG_CACHE_CTRL;
        end
        else
        begin
            dec.region = cmbd_pkg::RG_NONE;
        end
    end

endmodule

/* rtl/core/cmbd_store.sv */
module cmbd_store #(
    parameter int RAM_ADDR_BITS     = cmbd_pkg::RAM_ADDR_BITS_DEF,
    parameter int ROM_ADDR_BITS     = cmbd_pkg::ROM_ADDR_BITS_DEF,
    parameter int SCRATCH_ADDR_BITS = cmbd_pkg::SCRATCH_ADDR_BITS_DEF
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             rd_en,
    input  logic [31:0]      rd_addr,
    input  cmbd_pkg::mem_wr_t wr_cmd,
    output logic [31:0]      ram_q,
    output logic [31:0]      rom_q,
    output logic [31:0]      scr_q,
    output logic             busy
);

    localparam int RAM_IW = RAM_ADDR_BITS - 2;
    localparam int ROM_IW = ROM_ADDR_BITS - 2;
    localparam int SCR_IW = SCRATCH_ADDR_BITS - 2;
    localparam int CLR_W  = (RAM_IW > ROM_IW) ? RAM_IW : ROM_IW;

    logic [31:0] main_ram    [1 << RAM_IW];
    logic [31:0] boot_rom    [1 << ROM_IW];
    logic [31:0] scratch_ram [1 << SCR_IW];

    logic [CLR_W-1:0] clr_cnt_reg;
    logic             clr_busy_reg;

    // The clearing pass zeroes both large memories together, one entry per cycle.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_cnt_reg  <= '0;
            clr_busy_reg <= 1'b1;
        end
        else if (clr_busy_reg)
        begin
            clr_cnt_reg <= clr_cnt_reg + 1'b1;
            if (clr_cnt_reg == '1)
            begin
                clr_busy_reg <= 1'b0;
            end
        end
    end

    assign busy = clr_busy_reg;

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            main_ram[clr_cnt_reg[RAM_IW-1:0]] <= '0;
        end
        else if (wr_cmd.ram_we)
        begin
            main_ram[wr_cmd.addr[RAM_ADDR_BITS-1:2]] <= wr_cmd.data;
        end
        if (rd_en)
        begin
            ram_q <= main_ram[rd_addr[RAM_ADDR_BITS-1:2]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (clr_busy_reg)
        begin
            boot_rom[clr_cnt_reg[ROM_IW-1:0]] <= '0;
        end
        else if (wr_cmd.rom_we)
        begin
            boot_rom[wr_cmd.addr[ROM_ADDR_BITS-1:2]] <= wr_cmd.data;
        end
        if (rd_en)
        begin
            rom_q <= boot_rom[rd_addr[ROM_ADDR_BITS-1:2]];
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_cmd.scr_we)
        begin
            scratch_ram[wr_cmd.addr[SCRATCH_ADDR_BITS-1:2]] <= wr_cmd.data;
        end
        if (rd_en)
        begin
            scr_q <= scratch_ram[rd_addr[SCRATCH_ADDR_BITS-1:2]];
        end
    end

endmodule

/* rtl/core/console_memory_bus_decoder_core.sv */
// A transaction accepted at a clock edge waits in execute until the response register is
// empty or being drained, and its response is then registered.
// Throughput: one transaction per cycle outside the clearing pass and response stalls;
// the memory read is issued at acceptance and the read-modify-write lands when the
// transaction retires, with a one-entry bypass for back-to-back hits. Reset: rst_n clears
// all control state, then a clearing pass zeroes main RAM and boot ROM.
module console_memory_bus_decoder_core #(
    parameter int RAM_ADDR_BITS     = cmbd_pkg::RAM_ADDR_BITS_DEF,
    parameter int ROM_ADDR_BITS     = cmbd_pkg::ROM_ADDR_BITS_DEF,
    parameter int SCRATCH_ADDR_BITS = cmbd_pkg::SCRATCH_ADDR_BITS_DEF
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  cmbd_pkg::in_t  req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output cmbd_pkg::out_t rsp
);

    // Decode happens combinationally on the request port. The decoded transaction is
    // captured in the execute stage at the same edge that launches the memory reads.
    cmbd_pkg::dec_t dec;

    cmbd_decode #(
        .ROM_ADDR_BITS    (ROM_ADDR_BITS),
        .SCRATCH_ADDR_BITS(SCRATCH_ADDR_BITS)
    ) u_decode (
        .req(req),
        .dec(dec)
    );

    logic              busy;
    logic              req_accept;
    logic              advance;
    logic [31:0]       ram_q;
    logic [31:0]       rom_q;
    logic [31:0]       scr_q;
    cmbd_pkg::mem_wr_t wr_cmd;

    cmbd_pkg::dec_t    s1_reg;
    logic              s1_valid_reg;
    cmbd_pkg::mem_wr_t fwd_reg;
    logic              iso_reg;
    logic              iso_next;
    cmbd_pkg::out_t    rsp_reg;
    cmbd_pkg::out_t    rsp_next;
    logic              rsp_valid_reg;

    cmbd_store #(
        .RAM_ADDR_BITS    (RAM_ADDR_BITS),
        .ROM_ADDR_BITS    (ROM_ADDR_BITS),
        .SCRATCH_ADDR_BITS(SCRATCH_ADDR_BITS)
    ) u_store (
        .clk    (clk),
        .rst_n  (rst_n),
        .rd_en  (req_accept),
        .rd_addr(req.address),
        .wr_cmd (wr_cmd),
        .ram_q  (ram_q),
        .rom_q  (rom_q),
        .scr_q  (scr_q),
        .busy   (busy)
    );

    // The execute stage retires when the response register is empty or being drained.
    // A new transaction may enter in the same cycle, so the pipe runs at full rate.
    assign advance    = s1_valid_reg && (!rsp_valid_reg || rsp_ready);
    assign req_ready  = !busy && (!s1_valid_reg || advance);
    assign req_accept = req_valid && req_ready;

    // The memories return the value from before a write at the same edge. When the
    // transaction in execute was read at the edge where its predecessor wrote the same
    // entry, the bypass register supplies the freshly written word instead.
    logic        hit_ram;
    logic        hit_rom;
    logic        hit_scr;
    logic [31:0] word;

    assign hit_ram = fwd_reg.ram_we &&
                     (fwd_reg.addr[RAM_ADDR_BITS-1:2] == s1_reg.address[RAM_ADDR_BITS-1:2]);
    assign hit_rom = fwd_reg.rom_we &&
                     (fwd_reg.addr[ROM_ADDR_BITS-1:2] == s1_reg.address[ROM_ADDR_BITS-1:2]);
    assign hit_scr = fwd_reg.scr_we &&
                     (fwd_reg.addr[SCRATCH_ADDR_BITS-1:2] ==
                      s1_reg.address[SCRATCH_ADDR_BITS-1:2]);

    always_comb
    begin
        unique case (s1_reg.region)
            cmbd_pkg::RG_RAM:     word = hit_ram ? fwd_reg.data : ram_q;
            cmbd_pkg::RG_ROM:     word = hit_rom ? fwd_reg.data : rom_q;
            cmbd_pkg::RG_SCRATCH: word = hit_scr ? fwd_reg.data : scr_q;
            default:              word = '0;
        endcase
    end

    // Execute: lane extraction for reads, lane merge for writes, and the cache
    // isolation control. Write enables fire only when the transaction retires.
    always_comb
    begin
        wr_cmd                   = '0;
        wr_cmd.addr              = s1_reg.address;
        wr_cmd.data              = cmbd_pkg::lane_merge(word, s1_reg.write_data, s1_reg.size,
                                                         s1_reg.address[1:0]);
        iso_next                 = iso_reg;
        rsp_next                 = '0;
        rsp_next.isolation_event = cmbd_pkg::EV_NONE;
        unique case (s1_reg.region)
            cmbd_pkg::RG_SCRATCH:
            begin
                if (s1_reg.wr)
                begin
                    wr_cmd.scr_we = advance;
                end
                else
                begin
                    rsp_next.read_data = cmbd_pkg::lane_read(word, s1_reg.size,
                                                             s1_reg.address[1:0]);
                end
            end
            cmbd_pkg::RG_RAM:
            begin
                if (s1_reg.wr)
                begin
                    // Stores to main RAM are dropped while the cache is isolated.
                    wr_cmd.ram_we = advance && !iso_reg;
                end
                else
                begin
                    rsp_next.read_data = cmbd_pkg::lane_read(word, s1_reg.size,
                                                             s1_reg.address[1:0]);
                end
            end
            cmbd_pkg::RG_ROM:
            begin
                if (!s1_reg.wr)
                begin
                    rsp_next.read_data = cmbd_pkg::lane_read(word, s1_reg.size,
                                                             s1_reg.address[1:0]);
                end
            end
            cmbd_pkg::RG_EXPANSION:
            begin
                if (!s1_reg.wr)
                begin
                    rsp_next.read_data = cmbd_pkg::size_mask(s1_reg.size);
                end
            end
            cmbd_pkg::RG_HWREG:
            begin
                rsp_next.hw_forward = 1'b1;
            end
            cmbd_pkg::RG_LOAD:
            begin
                // Boot ROM loads store the whole word, whatever the size field says.
                wr_cmd.rom_we = advance;
                wr_cmd.data   = s1_reg.write_data;
            end
            cmbd_pkg::RG_CACHE_CTRL:
            begin
                if ((s1_reg.write_data == cmbd_pkg::ISO_ON_A ||
                     s1_reg.write_data == cmbd_pkg::ISO_ON_B) && !iso_reg)
                begin
                    iso_next                 = 1'b1;
                    rsp_next.isolation_event = cmbd_pkg::EV_ISOLATE;
                end
                else if ((s1_reg.write_data == cmbd_pkg::ISO_OFF_A ||
                          s1_reg.write_data == cmbd_pkg::ISO_OFF_B) && iso_reg)
                begin
                    iso_next                 = 1'b0;
                    rsp_next.isolation_event = cmbd_pkg::EV_UNISOLATE;
                end
            end
            default:
            begin
                rsp_next.read_data = '0;
            end
        endcase
        rsp_next.isolated_now = iso_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            fwd_reg       <= '0;
            iso_reg       <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (req_accept)
            begin
                s1_valid_reg <= 1'b1;
                // The bypass only matters for the transaction read at this very edge.
                fwd_reg      <= wr_cmd;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                iso_reg       <= iso_next;
                rsp_valid_reg <= 1'b1;
            end
            else if (rsp_ready)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers need no reset.
    always_ff @(posedge clk)
    begin
        if (req_accept)
        begin
            s1_reg <= dec;
        end
        if (advance)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // No transaction enters while the clearing pass runs.
    a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> !req_ready)
        else $error("transaction accepted during the clearing pass");

    // Isolation state moves only when a transaction retires.
    a_iso_stable: assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(iso_reg))
        else $error("cache isolation changed without a retiring transaction");

    // Main RAM is never written while the cache is isolated.
    a_ram_iso: assert property (@(posedge clk) disable iff (!rst_n)
        wr_cmd.ram_we |-> !iso_reg)
        else $error("main RAM written while the cache is isolated");

    // A stalled execute stage keeps its transaction.
    a_s1_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (s1_valid_reg && !advance) |=> (s1_valid_reg && $stable(s1_reg)))
        else $error("execute stage lost a stalled transaction");

endmodule

/* verif/cmbd_access_checker.sv */
`timescale 1ns / 100ps

module cmbd_access_checker
    import cmbd_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  in_t  req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  out_t rsp,
    output int   errors,
    output int   pending
);

    localparam int RAM_BITS = RAM_ADDR_BITS_DEF;
    localparam int ROM_BITS = ROM_ADDR_BITS_DEF;
    localparam int SCR_BITS = SCRATCH_ADDR_BITS_DEF;
    localparam int ROM_SEGS = 1 << (ROM_BITS - 16);

    // Main RAM and boot ROM are sparse; a missing entry reads as zero.
    logic [31:0] ram_words [logic [RAM_BITS-3:0]];
    logic [31:0] rom_words [logic [ROM_BITS-3:0]];
    logic [31:0] scratch_words [0:(1 << (SCR_BITS - 2)) - 1];
    logic        cache_iso;
    out_t        awaited_rsp [$];
    int          mismatches = 0;
    int          queued = 0;

    assign errors  = mismatches;
    assign pending = queued;

    function automatic logic [31:0] width_mask(input logic [1:0] sz);
        case (sz)
            SIZE_BYTE: return 32'h0000_00ff;
            SIZE_HALF: return 32'h0000_ffff;
            default:   return 32'hffff_ffff;
        endcase
    endfunction

    function automatic logic [4:0] lane_pos(input logic [1:0] sz, input logic [1:0] a);
        case (sz)
            SIZE_BYTE: return {a, 3'b000};
            SIZE_HALF: return {a[1], 4'b0000};
            default:   return 5'd0;
        endcase
    endfunction

    function automatic logic [31:0] extract_lane(input logic [31:0] word, input logic [1:0] sz,
                                                 input logic [1:0] a);
        return (word >> lane_pos(sz, a)) & width_mask(sz);
    endfunction

    function automatic logic [31:0] merge_lane(input logic [31:0] old, input logic [31:0] data,
                                               input logic [1:0] sz, input logic [1:0] a);
        logic [31:0] m;
        m = width_mask(sz) << lane_pos(sz, a);
        return (old & ~m) | ((data << lane_pos(sz, a)) & m);
    endfunction

    function automatic region_t decode_region(input logic [31:0] a);
        logic [15:0] seg;
        logic [12:0] low;
        logic        area_ok;
        seg     = a[31:16];
        low     = seg[12:0];
        area_ok = seg[15:13] inside {3'b000, 3'b100, 3'b101};
        if (area_ok && low == SEG_SCRATCH)
            return (a[15:0] < (1 << SCR_BITS)) ? RG_SCRATCH : RG_HWREG;
        if (area_ok && low < 13'h0080)
            return RG_RAM;
        if (seg == SEG_EXPANSION)
            return RG_EXPANSION;
        if (area_ok && low >= SEG_ROM_BASE && (low - SEG_ROM_BASE) < ROM_SEGS)
            return RG_ROM;
        if (a == CACHE_PORT)
            return RG_CACHE_CTRL;
        return RG_NONE;
    endfunction

    // Applies one transaction to the shadow memories and returns its response.
    function automatic out_t predict_access(input in_t t);
        out_t                r;
        logic [1:0]          sz;
        logic                wr;
        logic [31:0]         word;
        logic [RAM_BITS-3:0] ri;
        logic [ROM_BITS-3:0] oi;
        logic [SCR_BITS-3:0] si;
        r  = '0;
        sz = (t.size inside {SIZE_BYTE, SIZE_HALF}) ? t.size : SIZE_WORD;
        wr = (t.mode == MODE_WRITE);
        ri = t.address[RAM_BITS-1:2];
        oi = t.address[ROM_BITS-1:2];
        si = t.address[SCR_BITS-1:2];
        if (t.mode == MODE_LOAD)
        begin
            rom_words[oi] = t.write_data;
        end
        else if (t.mode != MODE_NOP)
        begin
            case (decode_region(t.address))
                RG_SCRATCH:
                begin
                    if (wr)
                        scratch_words[si] = merge_lane(scratch_words[si], t.write_data, sz,
                                                       t.address[1:0]);
                    else
                        r.read_data = extract_lane(scratch_words[si], sz, t.address[1:0]);
                end
                RG_HWREG:
                begin
                    r.hw_forward = 1'b1;
                end
                RG_RAM:
                begin
                    word = ram_words.exists(ri) ? ram_words[ri] : '0;
                    if (!wr)
                        r.read_data = extract_lane(word, sz, t.address[1:0]);
                    else if (!cache_iso)
                        ram_words[ri] = merge_lane(word, t.write_data, sz, t.address[1:0]);
                end
                RG_EXPANSION:
                begin
                    if (!wr)
                        r.read_data = width_mask(sz);
                end
                RG_ROM:
                begin
                    word = rom_words.exists(oi) ? rom_words[oi] : '0;
                    if (!wr)
                        r.read_data = extract_lane(word, sz, t.address[1:0]);
                end
                RG_CACHE_CTRL:
                begin
                    if (wr && sz == SIZE_WORD)
                    begin
                        if (t.write_data inside {ISO_ON_A, ISO_ON_B})
                        begin
                            if (!cache_iso)
                            begin
                                cache_iso         = 1'b1;
                                r.isolation_event = EV_ISOLATE;
                            end
                        end
                        else if (t.write_data inside {ISO_OFF_A, ISO_OFF_B})
                        begin
                            if (cache_iso)
                            begin
                                cache_iso         = 1'b0;
                                r.isolation_event = EV_UNISOLATE;
                            end
                        end
                    end
                end
                default:
                begin
                end
            endcase
        end
        r.isolated_now = cache_iso;
        return r;
    endfunction

    // The response side is handled first: a response can never belong to the
    // transaction accepted at the same edge.
    always @(posedge clk or negedge rst_n)
    begin
        out_t want;
        if (!rst_n)
        begin
            awaited_rsp.delete();
            ram_words.delete();
            rom_words.delete();
            foreach (scratch_words[i])
                scratch_words[i] = '0;
            cache_iso = 1'b0;
        end
        else
        begin
            if (rsp_valid && rsp_ready)
            begin
                if (awaited_rsp.size() == 0)
                begin
                    $error("response with no transaction outstanding: %h", rsp);
                    mismatches++;
                end
                else
                begin
                    want = awaited_rsp.pop_front();
                    if (rsp.read_data !== want.read_data)
                    begin
                        $error("read_data mismatch: expected %h, actual %h",
                               want.read_data, rsp.read_data);
                        mismatches++;
                    end
                    if (rsp.hw_forward !== want.hw_forward)
                    begin
                        $error("hw_forward mismatch: expected %b, actual %b",
                               want.hw_forward, rsp.hw_forward);
                        mismatches++;
                    end
                    if (rsp.isolation_event !== want.isolation_event)
                    begin
                        $error("isolation_event mismatch: expected %0d, actual %0d",
                               want.isolation_event, rsp.isolation_event);
                        mismatches++;
                    end
                    if (rsp.isolated_now !== want.isolated_now)
                    begin
                        $error("isolated_now mismatch: expected %b, actual %b",
                               want.isolated_now, rsp.isolated_now);
                        mismatches++;
                    end
                end
            end
            if (req_valid && req_ready)
                awaited_rsp.push_back(predict_access(req));
        end
        queued = awaited_rsp.size();
    end

endmodule

/* verif/tb_console_memory_bus_decoder_core.sv */
`timescale 1ns / 100ps

module tb_console_memory_bus_decoder_core;

    import cmbd_pkg::*;

    localparam int SCR_BITS     = SCRATCH_ADDR_BITS_DEF;
    localparam int RANDOM_ITEMS = 1550;

    // After reset the core zeroes main RAM and boot ROM, one word per cycle,
    // with no transaction accepted while it does so. That silent stretch is
    // by far the longest in a correct run, so the watchdog allows it three
    // times over before it gives up.
    localparam int WATCHDOG_LIMIT = 3 * (1 << 19);

    // The three address areas in which the memory map repeats.
    localparam logic [2:0] AREA_LOW      = 3'b000;
    localparam logic [2:0] AREA_CACHED   = 3'b100;
    localparam logic [2:0] AREA_UNCACHED = 3'b101;

    // The fourth size code, which the core decodes as a word.
    localparam logic [1:0] SIZE_ODD = 2'd3;

    logic clk;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    in_t  req;
    logic rsp_valid;
    logic rsp_ready;
    out_t rsp;
    int   fail_count;
    int   outstanding;

    // When set, neither side inserts any idle cycles.
    bit steady = 1'b0;

    // Scratchpad bytes that have been written since reset. The scratchpad
    // powers up undefined, so a read is only issued once every byte it
    // covers has been written.
    logic scr_written [0:(1 << SCR_BITS) - 1];

    // Small pools of word indexes, so that reads keep returning to data
    // written earlier, across all mirrors of the same location.
    logic [18:0] ram_hot [0:23];
    logic [16:0] rom_hot [0:15];

    console_memory_bus_decoder_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    cmbd_access_checker access_check (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp),
        .errors    (fail_count),
        .pending   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // Idle length for either side: mostly none or short, now and then long.
    function automatic int pick_gap();
        int p;
        p = $urandom_range(0, 99);
        if (steady || p < 55)
            return 0;
        if (p < 88)
            return $urandom_range(1, 3);
        if (p < 98)
            return $urandom_range(4, 12);
        return $urandom_range(20, 80);
    endfunction

    function automatic logic [2:0] pick_area();
        case ($urandom_range(0, 2))
            0:       return AREA_LOW;
            1:       return AREA_CACHED;
            default: return AREA_UNCACHED;
        endcase
    endfunction

    // Turns a scratchpad read of never-written bytes into a write of the same
    // lanes, and records which bytes every scratchpad write fills in.
    function automatic in_t guard_scratch(input in_t t);
        int  span;
        int  base;
        in_t g;
        g = t;
        if (g.mode inside {MODE_READ, MODE_WRITE}
            && g.address[31:29] inside {AREA_LOW, AREA_CACHED, AREA_UNCACHED}
            && g.address[28:16] == SEG_SCRATCH && g.address[15:SCR_BITS] == '0)
        begin
            span = (g.size == SIZE_BYTE) ? 1 : (g.size == SIZE_HALF) ? 2 : 4;
            base = g.address[SCR_BITS-1:0] & ~(span - 1);
            for (int i = 0; i < span; i++)
                if (!scr_written[base + i])
                    g.mode = MODE_WRITE;
            if (g.mode == MODE_WRITE)
                for (int i = 0; i < span; i++)
                    scr_written[base + i] = 1'b1;
        end
        return g;
    endfunction

    // One random transaction. Most of them land in decoded regions, with RAM
    // and ROM addresses drawn mostly from the hot pools; the rest are cache control
    // accesses, ROM loads, no-ops and fully random addresses that reach every bit.
    function automatic in_t random_access();
        in_t        t;
        int         pick;
        logic [2:0] area;
        t.mode       = $urandom_range(0, 1) ? MODE_WRITE : MODE_READ;
        t.size       = 2'($urandom_range(0, 3));
        t.write_data = $urandom();
        area         = pick_area();
        pick         = $urandom_range(0, 99);
        if (pick < 38)
        begin
            // Main RAM: bits 22:21 pick one of the four 2MB mirrors.
            t.address = {area, 6'd0, 2'($urandom()),
                         ($urandom_range(0, 4) == 0) ? 19'($urandom())
                                                     : ram_hot[$urandom_range(0, 23)],
                         2'($urandom())};
        end
        else if (pick < 53)
        begin
            t.address = {area, SEG_SCRATCH, 16'($urandom_range(0, (1 << SCR_BITS) - 1))};
        end
        else if (pick < 60)
        begin
            // Hardware register window, above the scratchpad in the same segment.
            t.address = {area, SEG_SCRATCH, 16'($urandom_range(1 << SCR_BITS, 16'hffff))};
        end
        else if (pick < 65)
        begin
            t.address = {SEG_EXPANSION, 16'($urandom())};
        end
        else if (pick < 77)
        begin
            t.address = {area, SEG_ROM_BASE[12:3], rom_hot[$urandom_range(0, 15)],
                         2'($urandom())};
        end
        else if (pick < 84)
        begin
            // Cache control port, mostly word writes of the known codes; the
            // rest are narrow, reads, other data or a neighboring address.
            t.mode    = ($urandom_range(0, 9) == 0) ? MODE_READ : MODE_WRITE;
            t.size    = ($urandom_range(0, 6) == 0) ? 2'($urandom_range(0, 3)) : SIZE_WORD;
            t.address = ($urandom_range(0, 7) == 0) ? CACHE_PORT ^ (32'd1 << $urandom_range(0, 31))
                                                    : CACHE_PORT;
            case ($urandom_range(0, 4))
                0:       t.write_data = ISO_ON_A;
                1:       t.write_data = ISO_ON_B;
                2:       t.write_data = ISO_OFF_A;
                3:       t.write_data = ISO_OFF_B;
                default: t.write_data = $urandom();
            endcase
        end
        else if (pick < 90)
        begin
            // ROM load: the upper bits are junk that must wrap away.
            t.mode    = MODE_LOAD;
            t.address = {13'($urandom()), rom_hot[$urandom_range(0, 15)], 2'($urandom())};
        end
        else if (pick < 93)
        begin
            t.mode    = MODE_NOP;
            t.address = $urandom();
        end
        else
        begin
            t.address = $urandom();
        end
        return t;
    endfunction

    // Presents one transaction after a random idle gap and holds it until the
    // core accepts it. Everything changes at the falling edge only.
    task automatic issue(input in_t t);
        int  gap;
        in_t item;
        item = guard_scratch(t);
        gap  = pick_gap();
        @(negedge clk);
        if (gap > 0)
        begin
            req_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        req_valid <= 1'b1;
        req       <= item;
        do
            @(posedge clk);
        while (!req_ready);
    endtask

    // Response side: ready is held high for a while, then dropped for a
    // stall of random length, so stalls land on every phase of the pipeline.
    initial
    begin
        int hold;
        int stall;
        rsp_ready = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            rsp_ready <= 1'b1;
            hold = $urandom_range(1, 20);
            repeat (hold - 1) @(negedge clk);
            stall = pick_gap();
            if (stall > 0)
            begin
                @(negedge clk);
                rsp_ready <= 1'b0;
                repeat (stall - 1) @(negedge clk);
            end
        end
    end

    // The watchdog restarts on every accepted transaction on either channel.
    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("simulation failed");
        $finish;
    end

    initial
    begin
        int sent;
        in_t t;
        rst_n     = 1'b0;
        req_valid = 1'b0;
        req       = '0;
        foreach (scr_written[i])
            scr_written[i] = 1'b0;
        foreach (ram_hot[i])
            ram_hot[i] = 19'($urandom());
        foreach (rom_hot[i])
            rom_hot[i] = 17'($urandom());
        // Keep the first and last word of each memory in the pools.
        ram_hot[0] = '0;
        ram_hot[1] = '1;
        rom_hot[0] = '0;
        rom_hot[1] = '1;

        repeat (5) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed part. A RAM read straight after reset must see the cleared
        // memory, then one word is written whole, patched through a halfword lane
        // and read back through different mirrors and lane widths.
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'h0000_0000, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h0000_0010, 32'hffff_ffff});
        issue(in_t'{MODE_READ,  SIZE_BYTE, 32'ha000_0013, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_HALF, 32'h8060_0012, 32'h1234_abcd});
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'h0020_0010, 32'h0000_0000});

        // Scratchpad at both ends of its range, seen through all three areas,
        // and the hardware register window just above it.
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h1f80_0000, 32'h0123_4567});
        issue(in_t'{MODE_READ,  SIZE_BYTE, 32'h9f80_0001, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'hbf80_03fc, 32'hffff_ffff});
        issue(in_t'{MODE_READ,  SIZE_HALF, 32'h1f80_03fe, 32'h0000_0000});
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'h1f80_0400, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_BYTE, 32'hbf80_ffff, 32'h0000_00a5});

        // Expansion port reads as all ones at the access width; writes vanish.
        issue(in_t'{MODE_READ,  SIZE_BYTE, 32'h1f00_0003, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h1f00_0000, 32'h1234_5678});

        // ROM load at an offset that wraps onto the last word, then a bus
        // write there that must be ignored, then a read back.
        issue(in_t'{MODE_LOAD,  SIZE_BYTE, 32'hffff_fffc, 32'hcafe_f00d});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h1fc7_fffc, 32'h0000_0000});
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'hbfc7_fffc, 32'h0000_0000});

        // Cache isolation: isolate, isolate again with no event, a RAM write
        // that must be dropped, a scratchpad write that must land, a RAM read
        // back, a narrow control write that must be ignored, then unisolate.
        issue(in_t'{MODE_WRITE, SIZE_WORD, CACHE_PORT,    ISO_ON_A});
        issue(in_t'{MODE_WRITE, SIZE_WORD, CACHE_PORT,    ISO_ON_B});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h0000_0010, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h1f80_0004, 32'h55aa_55aa});
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'h8000_0010, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_HALF, CACHE_PORT,    ISO_OFF_A});
        issue(in_t'{MODE_WRITE, SIZE_WORD, CACHE_PORT,    ISO_OFF_B});

        // No-op mode, the odd size code on a misaligned address, and unmapped
        // accesses at the top of the address space and just above the low area.
        issue(in_t'{MODE_NOP,   SIZE_ODD,  32'hffff_ffff, 32'hffff_ffff});
        issue(in_t'{MODE_READ,  SIZE_ODD,  32'h0000_0012, 32'h0000_0000});
        issue(in_t'{MODE_READ,  SIZE_WORD, 32'hffff_ffff, 32'h0000_0000});
        issue(in_t'{MODE_WRITE, SIZE_WORD, 32'h2000_0000, 32'hffff_ffff});

        // Random part. No-ops do not count toward the total.
        sent = 0;
        while (sent < RANDOM_ITEMS)
        begin
            if (sent % 100 == 0)
                steady = ($urandom_range(0, 3) == 0);
            t = random_access();
            issue(t);
            if (t.mode != MODE_NOP)
                sent++;
        end

        @(negedge clk);
        req_valid <= 1'b0;
        steady = 1'b0;

        // Drain: every response must arrive, then the bench waits on so that
        // any stray response the core might still produce is caught.
        while (outstanding != 0)
            @(negedge clk);
        repeat (8) @(negedge clk);

        if (fail_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
